[rtl/sav_pkg.sv]
// Shared types, widths, register codes and helpers of the sweep averager.
// No dependencies; every other file of the block but sav_checker uses this package.
package sav_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int MAX_SWEEP_SAMPLES = 4096;
	localparam int MEAN_W            = 32;
	localparam int SQ_W              = 48;
	localparam int STD_W             = 31;
	localparam int SUM_W             = 44;
	localparam int CNT_W             = 16;
	localparam int NUM_W             = 50;
	localparam int DEN_W             = 46;
	localparam int RAD_W             = 64;
	localparam int ROOT_W            = 32;
	localparam int STORE_W           = 2 * MEAN_W + 2 * SQ_W;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;

	localparam logic [12:0] SWEEP_SAMPLES_RST = 13'd1200;
	localparam logic [11:0] STIM_START_RST    = 12'd400;
	localparam logic [11:0] STIM_END_RST      = 12'd800;
	localparam logic [10:0] WINDOW_RST        = 11'd40;
	localparam logic [15:0] AMPLITUDE_RST     = 16'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SWEEP_SAMPLES = 3'd0,
		CFG_STIM_START    = 3'd1,
		CFG_STIM_END      = 3'd2,
		CFG_WINDOW        = 3'd3,
		CFG_AMPLITUDE     = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_SQUARE,
		ST_VARIANCE,
		ST_ROOT,
		ST_JOB_START,
		ST_JOB_WAIT,
		ST_RESULT
	} state_t;

	// Divisions run on the shared divider after the last sample of a sweep.
	typedef enum logic [2:0] {
		JOB_MEAN0,
		JOB_MEAN1,
		JOB_MEAN2,
		JOB_ACCESS_HI,
		JOB_ACCESS_LO,
		JOB_MEMB_HI,
		JOB_MEMB_LO
	} job_t;

	function automatic logic signed [31:0] clamp32(input logic signed [NUM_W-1:0] v);
		logic signed [NUM_W-1:0] hi;
		logic signed [NUM_W-1:0] lo;
		begin
			hi = NUM_W'(32'sh7FFF_FFFF);
			lo = -NUM_W'(64'sh8000_0000);
			if (v > hi) begin
				clamp32 = 32'sh7FFF_FFFF;
			end else if (v < lo) begin
				clamp32 = 32'sh8000_0000;
			end else begin
				clamp32 = v[31:0];
			end
		end
	endfunction

	// (a - b) / 2 rounded toward zero; always fits 32 bits.
	function automatic logic signed [31:0] half_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		logic signed [32:0] h;
		begin
			d = {a[31], a} - {b[31], b};
			h = (d + {32'd0, d[32]}) >>> 1;
			half_diff = h[31:0];
		end
	endfunction

endpackage

[rtl/sav_cfg_if.sv]
// Configuration write channel of the sweep averager.
// Depends on sav_pkg for the index and data widths.
interface sav_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sav_pkg::CFG_IDX_W-1:0]    index;
	logic [sav_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/sav_sample_if.sv]
// Sample request channel: one current and one potential sample per request.
// Depends on sav_pkg for the sample width.
interface sav_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sav_pkg::SAMPLE_BITS-1:0] current_sample;
	logic signed [sav_pkg::SAMPLE_BITS-1:0] potential_sample;
	logic                                  start_new_average;
	logic                                  last_of_sweep;

	modport source (output valid, output current_sample, output potential_sample,
		output start_new_average, output last_of_sweep, input ready);
	modport sink (input valid, input current_sample, input potential_sample,
		input start_new_average, input last_of_sweep, output ready);
endinterface

[rtl/sav_result_if.sv]
// Result channel: averaged values, deviations and end-of-sweep analysis.
// Depends on sav_pkg for the field widths.
interface sav_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [sav_pkg::MEAN_W-1:0] mean_current;
	logic [sav_pkg::STD_W-1:0]        std_current;
	logic signed [sav_pkg::MEAN_W-1:0] mean_potential;
	logic [sav_pkg::STD_W-1:0]        std_potential;
	logic signed [31:0]               leak_current;
	logic signed [31:0]               access_resistance;
	logic signed [31:0]               membrane_resistance;
	logic                             analysis_valid;
	logic                             divide_fault;

	modport source (output valid, output mean_current, output std_current,
		output mean_potential, output std_potential, output leak_current,
		output access_resistance, output membrane_resistance, output analysis_valid,
		output divide_fault, input ready);
	modport sink (input valid, input mean_current, input std_current,
		input mean_potential, input std_potential, input leak_current,
		input access_resistance, input membrane_resistance, input analysis_valid,
		input divide_fault, output ready);
endinterface

[rtl/sweep_averager_membrane_test.sv]
// Sweep ensemble averager with running deviation and membrane test analysis.
// Depends on sav_pkg, the three channel interfaces, sav_div and sav_sqrt.
//
// Channels: cfg writes one register per request (index, data) and is always
// ready; the user must write only while no sample is in flight, which the
// block itself does not enforce. samples takes one current/potential pair per
// request, results returns exactly one request per sample.
// Per sample: a sample is taken, its stored per-position mean and mean square
// are read, four serial dividers update them, and two serial square roots
// give the deviations. The last sample of a sweep adds seven passes of the
// shared divider for the window means and the resistance quotients.
// One sample is in work at a time; the next is taken once the previous
// result sits in the output register, so a stalled receiver holds only the
// result register and blocks the next sample's finish, not its start.
// Reset clears the sweep count, the position, the extremes, the window sums
// and the registers to their defaults; the per-position stores are not
// cleared and hold nothing meaningful until a sweep has written them.
module sweep_averager_membrane_test #(
	parameter int MAX_SWEEP_SAMPLES = sav_pkg::MAX_SWEEP_SAMPLES
) (
	input  logic clk,
	input  logic arst_n,
	sav_cfg_if.sink      cfg,
	sav_sample_if.sink   samples,
	sav_result_if.source results
);
	localparam int PW   = $clog2(MAX_SWEEP_SAMPLES);
	localparam int CMPW = (PW > 13 ? PW : 13) + 2;
	localparam int NW   = sav_pkg::NUM_W;
	localparam int DW   = sav_pkg::DEN_W;
	localparam int MW   = sav_pkg::MEAN_W;
	localparam int SW   = sav_pkg::SQ_W;
	localparam int XW   = sav_pkg::SAMPLE_BITS;
	localparam int AW   = sav_pkg::SUM_W;

	// configuration
	logic [12:0]        sweep_samples_q;
	logic [11:0]        stim_start_q;
	logic [11:0]        stim_end_q;
	logic [10:0]        window_q;
	logic signed [15:0] amp_q;

	// control and pass state
	sav_pkg::state_t state_q, state_d;
	sav_pkg::job_t   job_q;
	logic [sav_pkg::CNT_W-1:0] sweep_count_q;
	logic [PW-1:0]             pos_q;
	logic signed [31:0]        max_q;
	logic signed [31:0]        min_q;
	logic signed [AW-1:0]      wsum_q [3];
	logic                      out_valid_q;

	// item registers
	logic signed [XW-1:0] xi_q, xv_q;
	logic [2*XW-1:0]      sqi_q, sqv_q;
	logic                 last_q;
	logic [PW-1:0]        addr_q;
	logic [sav_pkg::STORE_W-1:0] store_q [MAX_SWEEP_SAMPLES];
	logic [sav_pkg::STORE_W-1:0] rd_q;
	logic signed [MW-1:0] cm_new_q, pm_new_q;
	logic signed [SW-1:0] cs_new_q, ps_new_q;
	logic signed [2*MW-1:0] prod_i_q, prod_v_q;
	logic [sav_pkg::STD_W-1:0] std_i_q, std_v_q;
	logic signed [AW-1:0] wmean_q [3];
	logic signed [31:0]   qv_q [4];
	logic                 fault_q;

	// output register
	logic signed [MW-1:0] o_mean_i_q, o_mean_v_q;
	logic [sav_pkg::STD_W-1:0] o_std_i_q, o_std_v_q;
	logic signed [31:0]   o_leak_q, o_ra_q, o_rm_q;
	logic                 o_avalid_q, o_fault_q;

	// control decode
	logic accept, div_start, sqrt_start, out_load;

	// datapath wires
	logic [PW-1:0]        rd_addr;
	logic signed [MW-1:0] cm_old, pm_old;
	logic signed [SW-1:0] cs_old, ps_old;
	logic signed [DW-1:0] den_count;
	logic [10:0]          w_eff;
	logic signed [NW-1:0] num0, num1, num2, num3;
	logic signed [DW-1:0] den0;
	logic signed [NW-1:0] quo0, quo1, quo2, quo3;
	logic                 div_done;
	logic signed [NW-1:0] job_num;
	logic signed [DW-1:0] job_den;
	logic signed [2*MW-1:0] var_i, var_v;
	logic [sav_pkg::RAD_W-1:0] rad_i, rad_v;
	logic [sav_pkg::ROOT_W-1:0] root_i, root_v;
	logic                 sqrt_done;
	logic signed [CMPW-1:0] posx, wx;
	logic signed [CMPW-1:0] ends [3];
	logic                 in_win [3];
	logic signed [31:0]   sat_q;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_samples_q <= sav_pkg::SWEEP_SAMPLES_RST;
			stim_start_q    <= sav_pkg::STIM_START_RST;
			stim_end_q      <= sav_pkg::STIM_END_RST;
			window_q        <= sav_pkg::WINDOW_RST;
			amp_q           <= sav_pkg::AMPLITUDE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sav_pkg::CFG_SWEEP_SAMPLES: sweep_samples_q <= cfg.data[12:0];
				sav_pkg::CFG_STIM_START:    stim_start_q    <= cfg.data[11:0];
				sav_pkg::CFG_STIM_END:      stim_end_q      <= cfg.data[11:0];
				sav_pkg::CFG_WINDOW:        window_q        <= cfg.data[10:0];
				sav_pkg::CFG_AMPLITUDE:     amp_q           <= cfg.data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sav_pkg::ST_IDLE:      if (samples.valid) state_d = sav_pkg::ST_READ;
			sav_pkg::ST_READ:      state_d = sav_pkg::ST_UPDATE;
			sav_pkg::ST_UPDATE:    if (div_done) state_d = sav_pkg::ST_SQUARE;
			sav_pkg::ST_SQUARE:    state_d = sav_pkg::ST_VARIANCE;
			sav_pkg::ST_VARIANCE:  state_d = sav_pkg::ST_ROOT;
			sav_pkg::ST_ROOT: begin
				if (sqrt_done) state_d = last_q ? sav_pkg::ST_JOB_START : sav_pkg::ST_RESULT;
			end
			sav_pkg::ST_JOB_START: state_d = sav_pkg::ST_JOB_WAIT;
			sav_pkg::ST_JOB_WAIT: begin
				if (div_done) begin
					state_d = (job_q == sav_pkg::JOB_MEMB_LO) ? sav_pkg::ST_RESULT
						: sav_pkg::ST_JOB_START;
				end
			end
			sav_pkg::ST_RESULT: if (!out_valid_q || results.ready) state_d = sav_pkg::ST_IDLE;
			default: state_d = sav_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		samples.ready = 1'b0;
		div_start     = 1'b0;
		sqrt_start    = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			sav_pkg::ST_IDLE:      samples.ready = 1'b1;
			sav_pkg::ST_READ:      div_start = 1'b1;
			sav_pkg::ST_JOB_START: div_start = 1'b1;
			sav_pkg::ST_VARIANCE:  sqrt_start = 1'b1;
			sav_pkg::ST_RESULT:    out_load = !out_valid_q || results.ready;
			default: ;
		endcase
	end

	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sav_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-position store: one read on accept, one write after the update
	assign rd_addr = samples.start_new_average ? '0 : pos_q;

	// on the first sweep of an average the old entry drops out of the update
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= (samples.start_new_average || sweep_count_q == '0) ? '0
				: store_q[rd_addr];
		end
		if (state_q == sav_pkg::ST_SQUARE) begin
			store_q[addr_q] <= {cm_new_q, cs_new_q, pm_new_q, ps_new_q};
		end
	end

	assign cm_old = rd_q[2*MW+2*SW-1 -: MW];
	assign cs_old = rd_q[MW+2*SW-1 -: SW];
	assign pm_old = rd_q[MW+SW-1 -: MW];
	assign ps_old = rd_q[SW-1:0];

	assign den_count = DW'({1'b0, sweep_count_q} + 17'd1);
	assign w_eff     = (window_q == '0) ? 11'd1 : window_q;

	// (new - old) numerators for three of the four running averages
	assign num1 = {{(NW-2*XW-16){1'b0}}, sqi_q, 16'h0000} - {{(NW-SW){cs_old[SW-1]}}, cs_old};
	assign num2 = {{(NW-XW-8){xv_q[XW-1]}}, xv_q, 8'h00} - {{(NW-MW){pm_old[MW-1]}}, pm_old};
	assign num3 = {{(NW-2*XW-16){1'b0}}, sqv_q, 16'h0000} - {{(NW-SW){ps_old[SW-1]}}, ps_old};

	always_comb begin
		job_num = {{(NW-AW){wsum_q[0][AW-1]}}, wsum_q[0]};
		job_den = DW'(w_eff);
		case (job_q)
			sav_pkg::JOB_MEAN0: job_num = {{(NW-AW){wsum_q[0][AW-1]}}, wsum_q[0]};
			sav_pkg::JOB_MEAN1: job_num = {{(NW-AW){wsum_q[1][AW-1]}}, wsum_q[1]};
			sav_pkg::JOB_MEAN2: job_num = {{(NW-AW){wsum_q[2][AW-1]}}, wsum_q[2]};
			default: begin
				job_num = {{(NW-40){amp_q[15]}}, amp_q, 24'h000000};
				case (job_q)
					sav_pkg::JOB_ACCESS_HI: job_den = DW'(max_q) - DW'(wmean_q[0]);
					sav_pkg::JOB_ACCESS_LO: job_den = DW'(min_q) - DW'(wmean_q[1]);
					sav_pkg::JOB_MEMB_HI:   job_den = DW'(wmean_q[1]) - DW'(wmean_q[0]);
					default:                job_den = DW'(wmean_q[2]) - DW'(wmean_q[1]);
				endcase
			end
		endcase
	end

	always_comb begin
		if (state_q == sav_pkg::ST_READ) begin
			num0 = {{(NW-XW-8){xi_q[XW-1]}}, xi_q, 8'h00} - {{(NW-MW){cm_old[MW-1]}}, cm_old};
			den0 = den_count;
		end else begin
			num0 = job_num;
			den0 = job_den;
		end
	end

	sav_div #(.NW(NW), .DW(DW)) u_div0 (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num0), .den(den0), .done(div_done), .quo(quo0)
	);
	sav_div #(.NW(NW), .DW(DW)) u_div1 (
		.clk(clk), .arst_n(arst_n), .start(state_q == sav_pkg::ST_READ),
		.num(num1), .den(den_count), .done(), .quo(quo1)
	);
	sav_div #(.NW(NW), .DW(DW)) u_div2 (
		.clk(clk), .arst_n(arst_n), .start(state_q == sav_pkg::ST_READ),
		.num(num2), .den(den_count), .done(), .quo(quo2)
	);
	sav_div #(.NW(NW), .DW(DW)) u_div3 (
		.clk(clk), .arst_n(arst_n), .start(state_q == sav_pkg::ST_READ),
		.num(num3), .den(den_count), .done(), .quo(quo3)
	);

	// variance; a negative one gives a zero deviation
	assign var_i = {{(2*MW-SW){cs_new_q[SW-1]}}, cs_new_q} - prod_i_q;
	assign var_v = {{(2*MW-SW){ps_new_q[SW-1]}}, ps_new_q} - prod_v_q;
	assign rad_i = var_i[2*MW-1] ? '0 : sav_pkg::RAD_W'(var_i);
	assign rad_v = var_v[2*MW-1] ? '0 : sav_pkg::RAD_W'(var_v);

	sav_sqrt #(.RW(sav_pkg::RAD_W)) u_sqrt_i (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.rad(rad_i), .done(sqrt_done), .root(root_i)
	);
	sav_sqrt #(.RW(sav_pkg::RAD_W)) u_sqrt_v (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.rad(rad_v), .done(), .root(root_v)
	);

	// window membership: end - W - 2 <= pos < end - 2
	assign posx    = CMPW'(addr_q);
	assign wx      = CMPW'(w_eff);
	assign ends[0] = CMPW'(stim_start_q);
	assign ends[1] = CMPW'(stim_end_q);
	assign ends[2] = CMPW'(sweep_samples_q);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			in_win[k] = (posx >= ends[k] - wx - CMPW'(2)) && (posx < ends[k] - CMPW'(2));
		end
	end

	// saturated quotient for a zero denominator
	always_comb begin
		if (amp_q > 16'sd0) begin
			sat_q = 32'sh7FFF_FFFF;
		end else if (amp_q < 16'sd0) begin
			sat_q = 32'sh8000_0000;
		end else begin
			sat_q = '0;
		end
	end

	// pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_count_q <= '0;
			pos_q         <= '0;
			max_q         <= 32'sh8000_0000;
			min_q         <= 32'sh7FFF_FFFF;
			for (int k = 0; k < 3; k++) wsum_q[k] <= '0;
			job_q         <= sav_pkg::JOB_MEAN0;
			fault_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				fault_q <= 1'b0;
				job_q   <= sav_pkg::JOB_MEAN0;
				if (samples.start_new_average) begin
					sweep_count_q <= '0;
					pos_q         <= '0;
					max_q         <= 32'sh8000_0000;
					min_q         <= 32'sh7FFF_FFFF;
					for (int k = 0; k < 3; k++) wsum_q[k] <= '0;
				end
			end
			if (state_q == sav_pkg::ST_SQUARE) begin
				if (cm_new_q > max_q) max_q <= cm_new_q;
				if (cm_new_q < min_q) min_q <= cm_new_q;
				for (int k = 0; k < 3; k++) begin
					if (in_win[k]) wsum_q[k] <= wsum_q[k] + AW'(cm_new_q);
				end
			end
			if (state_q == sav_pkg::ST_JOB_WAIT && div_done) begin
				if (job_q >= sav_pkg::JOB_ACCESS_HI && job_den == '0) fault_q <= 1'b1;
				if (job_q != sav_pkg::JOB_MEMB_LO) job_q <= sav_pkg::job_t'(job_q + 3'd1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					if (sweep_count_q != '1) sweep_count_q <= sweep_count_q + 1'b1;
					pos_q <= '0;
					max_q <= 32'sh8000_0000;
					min_q <= 32'sh7FFF_FFFF;
					for (int k = 0; k < 3; k++) wsum_q[k] <= '0;
				end else begin
					pos_q <= (pos_q == PW'(MAX_SWEEP_SAMPLES - 1)) ? '0 : pos_q + 1'b1;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			xi_q   <= samples.current_sample;
			xv_q   <= samples.potential_sample;
			sqi_q  <= samples.current_sample * samples.current_sample;
			sqv_q  <= samples.potential_sample * samples.potential_sample;
			last_q <= samples.last_of_sweep;
			addr_q <= rd_addr;
		end
		if (state_q == sav_pkg::ST_UPDATE && div_done) begin
			cm_new_q <= cm_old + quo0[MW-1:0];
			cs_new_q <= cs_old + quo1[SW-1:0];
			pm_new_q <= pm_old + quo2[MW-1:0];
			ps_new_q <= ps_old + quo3[SW-1:0];
		end
		if (state_q == sav_pkg::ST_SQUARE) begin
			prod_i_q <= cm_new_q * cm_new_q;
			prod_v_q <= pm_new_q * pm_new_q;
		end
		if (state_q == sav_pkg::ST_ROOT && sqrt_done) begin
			std_i_q <= root_i[sav_pkg::STD_W-1:0];
			std_v_q <= root_v[sav_pkg::STD_W-1:0];
		end
		if (state_q == sav_pkg::ST_JOB_WAIT && div_done) begin
			case (job_q)
				sav_pkg::JOB_MEAN0:     wmean_q[0] <= quo0[AW-1:0];
				sav_pkg::JOB_MEAN1:     wmean_q[1] <= quo0[AW-1:0];
				sav_pkg::JOB_MEAN2:     wmean_q[2] <= quo0[AW-1:0];
				sav_pkg::JOB_ACCESS_HI: qv_q[0] <= (job_den == '0) ? sat_q : sav_pkg::clamp32(quo0);
				sav_pkg::JOB_ACCESS_LO: qv_q[1] <= (job_den == '0) ? sat_q : sav_pkg::clamp32(quo0);
				sav_pkg::JOB_MEMB_HI:   qv_q[2] <= (job_den == '0) ? sat_q : sav_pkg::clamp32(quo0);
				default:                qv_q[3] <= (job_den == '0) ? sat_q : sav_pkg::clamp32(quo0);
			endcase
		end
		if (out_load) begin
			o_mean_i_q <= cm_new_q;
			o_mean_v_q <= pm_new_q;
			o_std_i_q  <= std_i_q;
			o_std_v_q  <= std_v_q;
			o_avalid_q <= last_q;
			if (last_q) begin
				o_leak_q  <= sav_pkg::clamp32({{(NW-AW){wmean_q[0][AW-1]}}, wmean_q[0]});
				o_ra_q    <= sav_pkg::half_diff(qv_q[0], qv_q[1]);
				o_rm_q    <= sav_pkg::half_diff(qv_q[2], qv_q[3]);
				o_fault_q <= fault_q;
			end else begin
				o_leak_q  <= '0;
				o_ra_q    <= '0;
				o_rm_q    <= '0;
				o_fault_q <= 1'b0;
			end
		end
	end

	assign results.valid               = out_valid_q;
	assign results.mean_current        = o_mean_i_q;
	assign results.std_current         = o_std_i_q;
	assign results.mean_potential      = o_mean_v_q;
	assign results.std_potential       = o_std_v_q;
	assign results.leak_current        = o_leak_q;
	assign results.access_resistance   = o_ra_q;
	assign results.membrane_resistance = o_rm_q;
	assign results.analysis_valid      = o_avalid_q;
	assign results.divide_fault        = o_fault_q;
endmodule

[rtl/sav_div.sv]
// Bit-serial signed divider, quotient truncated toward zero, one bit a cycle.
// Depends only on sav_pkg for its default widths; the instantiating module passes the widths.
module sav_div #(
	parameter int NW = sav_pkg::NUM_W,
	parameter int DW = sav_pkg::DEN_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          neg_q;
	logic [NW-1:0] shift_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, shift_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CW'(1);
			end
		end
	end

	// shift register takes the dividend in and the quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= num[NW-1] ? -num : num;
			den_q   <= den[DW-1] ? -den : den;
			rem_q   <= '0;
			neg_q   <= num[NW-1] ^ den[DW-1];
		end else if (cnt_q != '0) begin
			rem_q   <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			shift_q <= {shift_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(shift_q) : $signed(shift_q);
endmodule

[rtl/sav_sqrt.sv]
// Bit-serial integer square root, floor result, two radicand bits a cycle.
// Depends only on sav_pkg, for its default width.
module sav_sqrt #(
	parameter int RW = sav_pkg::RAD_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW-1:0]   rad,
	output logic            done,
	output logic [RW/2-1:0] root
);
	localparam int QW = RW / 2;
	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW-1:0] rad_q;
	logic [QW+2:0] rem_q;
	logic [QW-1:0] root_q;
	logic [QW+2:0] rem_next;
	logic [QW+2:0] trial;
	logic          fits;

	assign rem_next = {rem_q[QW:0], rad_q[RW-1:RW-2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign fits     = rem_next >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RW-3:0], 2'b00};
			rem_q  <= fits ? rem_next - trial : rem_next;
			root_q <= {root_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

[rtl/sav_checker.sv]
// Port-level checks of the sweep averager, attached to the top level by bind.
// Depends on sweep_averager_membrane_test and its channel interfaces.
module sav_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] mean_current,
	input logic [31:0] leak_current,
	input logic [31:0] access_resistance,
	input logic [31:0] membrane_resistance,
	input logic        analysis_valid,
	input logic        divide_fault
);
	// a stalled result request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_current))
		else $error("result request dropped or changed while stalled");

	// one sample in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while another is in work");

	// analysis fields stay zero off the last sample
	a_no_analysis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !analysis_valid |-> leak_current == '0 && access_resistance == '0
			&& membrane_resistance == '0 && !divide_fault)
		else $error("analysis fields set on an ordinary sample");
endmodule

bind sweep_averager_membrane_test sav_checker u_sav_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (samples.valid),
	.in_ready            (samples.ready),
	.out_valid           (results.valid),
	.out_ready           (results.ready),
	.mean_current        (results.mean_current),
	.leak_current        (results.leak_current),
	.access_resistance   (results.access_resistance),
	.membrane_resistance (results.membrane_resistance),
	.analysis_valid      (results.analysis_valid),
	.divide_fault        (results.divide_fault)
);

[verif/tb.sv]
// Testbench for the sweep averager: drives sample requests, predicts every
// result in its own model and checks every field of the result channel.
// Depends on sav_pkg, the three channel interfaces and the block's top level.
`timescale 1ns / 1ps

module tb;
	import sav_pkg::*;

	localparam int DEPTH      = 4096;
	localparam int STALL_MAX  = 20000;
	localparam int LONG_HOLD  = 3000;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		logic signed [15:0] cur;
		logic signed [15:0] pot;
		logic               fresh;
		logic               sweep_end;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] mean_i;
		logic [30:0]        std_i;
		logic signed [31:0] mean_v;
		logic [30:0]        std_v;
		logic signed [31:0] leak;
		logic signed [31:0] r_access;
		logic signed [31:0] r_memb;
		logic               valid_an;
		logic               fault;
	} avg_result_t;

	logic clk;
	logic arst_n;

	sav_cfg_if    cfg();
	sav_sample_if smp();
	sav_result_if res();

	sweep_averager_membrane_test u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.samples(smp),
		.results(res)
	);

	// predictor state
	longint mean_i_mem [DEPTH];
	longint sq_i_mem   [DEPTH];
	longint mean_v_mem [DEPTH];
	longint sq_v_mem   [DEPTH];
	int unsigned sweeps_done;
	int unsigned pos;
	longint peak_hi;
	longint peak_lo;
	longint win_sum [3];
	int unsigned reg_len;
	int unsigned reg_start;
	int unsigned reg_end;
	int unsigned reg_win;
	longint      reg_amp;

	sample_t     pending_samples [$];
	avg_result_t expected_results [$];
	sample_t     on_bus;
	int          errors;
	bit          calm;
	int          results_seen;

	// generator-side view of which positions have been written
	int gen_written;
	int gen_sweeps;
	int gen_total;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint spread(longint msq, longint m);
		longint var_q;
		var_q = msq - m * m;
		return (var_q < 0) ? 0 : root_floor(longint'(var_q));
	endfunction

	function automatic longint amp_ratio(longint den, ref bit fault);
		if (den == 0) begin
			fault = 1'b1;
			return (reg_amp > 0) ? 64'sd2147483647 : ((reg_amp < 0) ? -64'sd2147483648 : 0);
		end
		return clamp_32((reg_amp * 64'sd16777216) / den);
	endfunction

	function automatic void restart_sweep();
		pos = 0;
		peak_hi = -64'sd2147483648;
		peak_lo = 64'sd2147483647;
		for (int k = 0; k < 3; k++)
			win_sum[k] = 0;
	endfunction

	function automatic void apply_reg(cfg_idx_t idx, logic [15:0] v);
		case (idx)
			CFG_SWEEP_SAMPLES: reg_len = v[12:0];
			CFG_STIM_START:    reg_start = v[11:0];
			CFG_STIM_END:      reg_end = v[11:0];
			CFG_WINDOW:        reg_win = v[10:0];
			CFG_AMPLITUDE:     reg_amp = longint'($signed(v));
			default: ;
		endcase
	endfunction

	function automatic avg_result_t average_sample(sample_t s);
		avg_result_t r;
		longint xi, xv, n, mi, mv, w, w0, w1, w2, qa, qb, qc, qd;
		longint ends [3];
		bit fault;
		xi = longint'(s.cur);
		xv = longint'(s.pot);
		if (s.fresh) begin
			sweeps_done = 0;
			restart_sweep();
		end
		n = longint'(sweeps_done) + 1;
		mean_i_mem[pos] += (xi * 256 - mean_i_mem[pos]) / n;
		sq_i_mem[pos]   += (xi * xi * 65536 - sq_i_mem[pos]) / n;
		mean_v_mem[pos] += (xv * 256 - mean_v_mem[pos]) / n;
		sq_v_mem[pos]   += (xv * xv * 65536 - sq_v_mem[pos]) / n;
		mi = mean_i_mem[pos];
		mv = mean_v_mem[pos];
		r = '0;
		r.mean_i = mi[31:0];
		r.std_i  = 31'(spread(sq_i_mem[pos], mi));
		r.mean_v = mv[31:0];
		r.std_v  = 31'(spread(sq_v_mem[pos], mv));
		if (mi > peak_hi)
			peak_hi = mi;
		if (mi < peak_lo)
			peak_lo = mi;
		w = (reg_win == 0) ? 1 : longint'(reg_win);
		ends[0] = reg_start;
		ends[1] = reg_end;
		ends[2] = reg_len;
		for (int k = 0; k < 3; k++)
			if (longint'(pos) >= ends[k] - w - 2 && longint'(pos) < ends[k] - 2)
				win_sum[k] += mi;
		if (s.sweep_end) begin
			fault = 1'b0;
			w0 = win_sum[0] / w;
			w1 = win_sum[1] / w;
			w2 = win_sum[2] / w;
			qa = amp_ratio(peak_hi - w0, fault);
			qb = amp_ratio(peak_lo - w1, fault);
			qc = amp_ratio(w1 - w0, fault);
			qd = amp_ratio(w2 - w1, fault);
			r.leak     = 32'(clamp_32(w0));
			r.r_access = 32'(clamp_32((qa - qb) / 2));
			r.r_memb   = 32'(clamp_32((qc - qd) / 2));
			r.valid_an = 1'b1;
			r.fault    = fault;
			if (sweeps_done < 65535)
				sweeps_done++;
			restart_sweep();
		end else begin
			pos = (pos + 1 >= DEPTH) ? 0 : pos + 1;
		end
		return r;
	endfunction

	// Sample driver: pops pending requests, idles in random bursts.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		sample_t nxt;
		logic    nv;
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.current_sample <= '0;
			smp.potential_sample <= '0;
			smp.start_new_average <= 1'b0;
			smp.last_of_sweep <= 1'b0;
			gap_left = 0;
		end else begin
			if (smp.valid && smp.ready)
				expected_results.push_back(average_sample(on_bus));
			if (!smp.valid || smp.ready) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0 && !calm
						&& $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(1, 11);
				end else if (pending_samples.size() > 0) begin
					nxt = pending_samples.pop_front();
					on_bus <= nxt;
					smp.current_sample <= nxt.cur;
					smp.potential_sample <= nxt.pot;
					smp.start_new_average <= nxt.fresh;
					smp.last_of_sweep <= nxt.sweep_end;
					nv = 1'b1;
				end
				smp.valid <= nv;
			end
		end
	end

	// Result monitor: checks against the oldest prediction, stalls at random.
	int hold_left;
	bit long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		avg_result_t got;
		avg_result_t want;
		logic nr;
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left = 0;
			long_hold_done = 0;
			results_seen = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.mean_i   = res.mean_current;
				got.std_i    = res.std_current;
				got.mean_v   = res.mean_potential;
				got.std_v    = res.std_potential;
				got.leak     = res.leak_current;
				got.r_access = res.access_resistance;
				got.r_memb   = res.membrane_resistance;
				got.valid_an = res.analysis_valid;
				got.fault    = res.divide_fault;
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("unexpected result request: %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= MAX_SHOWN)
							$display("result %0d mismatch\n  expected %p\n  actual   %p",
								results_seen, want, got);
					end
				end
			end
			nr = 1'b1;
			if (!long_hold_done && results_seen == 150) begin
				// hold off long enough for the block to back up into the sender
				long_hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 11) - 1;
				nr = 1'b0;
			end
			res.ready <= nr;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, v);
		cfg.valid <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] len, logic [15:0] st, logic [15:0] en,
			logic [15:0] w, logic [15:0] amp);
		write_reg(CFG_SWEEP_SAMPLES, len);
		write_reg(CFG_STIM_START, st);
		write_reg(CFG_STIM_END, en);
		write_reg(CFG_WINDOW, w);
		write_reg(CFG_AMPLITUDE, amp);
	endtask

	// Wait for every request to come back, then let the block settle.
	task automatic drain();
		do @(negedge clk);
		while (pending_samples.size() > 0 || expected_results.size() > 0 || smp.valid);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [15:0] edge_value(int i);
		case (i % 7)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0001;
			5: return 16'h5555;
			default: return 16'hAAAA;
		endcase
	endfunction

	// Queue one sweep; after the first sweep of an average, stay inside the
	// positions already written. Pattern: 0 random, 1 extremes, 2 constant.
	task automatic add_sweep(int len, bit fresh, int pattern);
		sample_t s;
		logic [15:0] hold_i;
		logic [15:0] hold_v;
		if (fresh)
			gen_sweeps = 0;
		if (gen_sweeps > 0 && len > gen_written)
			len = gen_written;
		if (len < 1)
			len = 1;
		hold_i = $urandom;
		hold_v = $urandom;
		@(negedge clk);
		for (int i = 0; i < len; i++) begin
			case (pattern)
				1: begin
					s.cur = edge_value(i);
					s.pot = edge_value(i + 3);
				end
				2: begin
					s.cur = hold_i;
					s.pot = hold_v;
				end
				default: begin
					s.cur = $urandom;
					s.pot = $urandom;
				end
			endcase
			s.fresh = fresh && (i == 0);
			s.sweep_end = (i == len - 1);
			pending_samples.push_back(s);
		end
		gen_total += len;
		gen_sweeps++;
		if (len > gen_written)
			gen_written = len;
	endtask

	initial begin
		errors = 0;
		calm = 0;
		gen_written = 0;
		gen_sweeps = 0;
		gen_total = 0;
		for (int i = 0; i < DEPTH; i++) begin
			mean_i_mem[i] = 0;
			sq_i_mem[i] = 0;
			mean_v_mem[i] = 0;
			sq_v_mem[i] = 0;
		end
		sweeps_done = 0;
		restart_sweep();
		reg_len = SWEEP_SAMPLES_RST;
		reg_start = STIM_START_RST;
		reg_end = STIM_END_RST;
		reg_win = WINDOW_RST;
		reg_amp = longint'($signed(AMPLITUDE_RST));
		cfg.valid = 1'b0;
		cfg.index = CFG_SWEEP_SAMPLES;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, constant sweep for zero denominators
		write_all(16'd24, 16'd8, 16'd16, 16'd3, 16'd20);
		add_sweep(24, 1, 1);
		add_sweep(6, 0, 2);
		drain();

		// register extremes: windows off the sweep, most negative amplitude
		write_all(16'd4096, 16'd4095, 16'd4095, 16'd1024, 16'h8000);
		add_sweep(20, 0, 0);
		add_sweep(12, 0, 1);
		drain();

		// zero window, windows ending before position 0, largest amplitude
		write_all(16'd8, 16'd0, 16'd0, 16'd0, 16'h7FFF);
		add_sweep(8, 1, 0);
		add_sweep(8, 0, 2);
		drain();

		write_reg(CFG_AMPLITUDE, 16'd0);
		add_sweep(8, 0, 2);
		drain();

		// main random part: mostly full sweeps with random content
		write_all(16'd40, 16'd12, 16'd30, 16'd5, 16'($urandom));
		while (gen_total < 520) begin
			int len;
			int r;
			r = $urandom_range(0, 9);
			len = (r < 8) ? 40 : $urandom_range(1, 60);
			add_sweep(len, $urandom_range(0, 7) == 0, (r == 9) ? 2 : 0);
		end
		drain();

		// last part without idling
		write_all(16'd16, 16'd4, 16'd10, 16'd2, 16'hFFFB);
		calm = 1;
		while (gen_total < 620)
			add_sweep(16, $urandom_range(0, 5) == 0, $urandom_range(0, 2));
		drain();

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/sav_pkg.sv
rtl/sav_cfg_if.sv
rtl/sav_sample_if.sv
rtl/sav_result_if.sv
rtl/sav_div.sv
rtl/sav_sqrt.sv
rtl/sweep_averager_membrane_test.sv
rtl/sav_checker.sv
verif/tb.sv
